// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the encoder checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, quiet while reset is high
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Clocked assertion that also watches reset itself
`define ASSERT_CLK_NORST(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

// ===== src/ddz_pkg.sv =====
// ----------------------------------------------------------------------------
// ddz_pkg
// Shared types and fixed constants of the delta / double delta encoder.
// ----------------------------------------------------------------------------
package ddz_pkg;

   // Sample index field and reference store depth (index wraps on the store)
   localparam int INDEX_BITS       = 12;
   localparam int MAX_SAMPLES      = 2 ** INDEX_BITS;

   // Width of the reported code-width fields
   localparam int WIDTH_FIELD_BITS = 5;

   typedef enum logic {
      MODE_REFERENCE = 1'b0,
      MODE_COMPARE   = 1'b1
   } mode_type;

   // Per-request control travelling down the pipeline
   typedef struct packed {
      logic first;    // index 0: start of a series
      logic compare;  // compared series
      logic last;     // final request of the series
   } ctrl_type;

endpackage

// ===== src/delta_double_delta_zigzag_encoder.sv =====
// ----------------------------------------------------------------------------
// delta_double_delta_zigzag_encoder
// Delta and double delta zigzag encoder for sensor series, with statistics.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Handshake              Carries
// req      in   req_valid / req_stall  mode, sample, sample_index, last
// rsp      out  rsp_valid / rsp_stall  delta codes, series statistics
//
// One request per cycle sustained unless rsp_stall holds the pipeline; a taken
// request passes intake with reference RAM access, then double delta, then output.
// The rate is set by the reference-delta RAM: one write or one read per request.
// Reset is synchronous and clears the stage valids, the previous sample and
// the statistics; the reference RAM is not cleared and holds junk until written.
// rsp_stall holds the output register and ripples back only through full stages.
//
module delta_double_delta_zigzag_encoder #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic                                    req_mode,
   input  logic signed [SAMPLE_BITS-1:0]           req_sample,
   input  logic [ddz_pkg::INDEX_BITS-1:0]          req_sample_index,
   input  logic                                    req_last,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [SAMPLE_BITS:0]                    rsp_delta_code,
   output logic [SAMPLE_BITS+1:0]                  rsp_double_delta_code,
   output logic signed [SAMPLE_BITS-1:0]           rsp_sample_min,
   output logic signed [SAMPLE_BITS-1:0]           rsp_sample_max,
   output logic signed [SAMPLE_BITS:0]             rsp_delta_min,
   output logic signed [SAMPLE_BITS:0]             rsp_delta_max,
   output logic signed [SAMPLE_BITS+1:0]           rsp_ddelta_min,
   output logic signed [SAMPLE_BITS+1:0]           rsp_ddelta_max,
   output logic [ddz_pkg::WIDTH_FIELD_BITS-1:0]    rsp_delta_width,
   output logic [ddz_pkg::WIDTH_FIELD_BITS-1:0]    rsp_ddelta_width,
   output logic                                    rsp_stats_valid
);

   // Hand-off from the delta pipeline to the statistics stage
   logic                            out_free;
   logic                            item_valid;
   ddz_pkg::ctrl_type               item_ctrl;
   logic signed [SAMPLE_BITS-1:0]   item_sample;
   logic signed [SAMPLE_BITS:0]     item_delta;
   logic signed [SAMPLE_BITS+1:0]   item_ddelta;
   logic [SAMPLE_BITS:0]            item_dcode;
   logic [SAMPLE_BITS+1:0]          item_ddcode;

   // Take the request, form the delta, write or read the reference RAM,
   // then form the double delta and both zigzag codes
   ddz_delta_stage #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_delta (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_sample       (req_sample),
      .req_sample_index (req_sample_index),
      .req_last         (req_last),
      .out_free         (out_free),
      .item_valid       (item_valid),
      .item_ctrl        (item_ctrl),
      .item_sample      (item_sample),
      .item_delta       (item_delta),
      .item_ddelta      (item_ddelta),
      .item_dcode       (item_dcode),
      .item_ddcode      (item_ddcode)
   );

   // Fold into the running statistics in request order, report and clear
   // them on the final request of a series
   ddz_stats_stage #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_stats (
      .clock                 (clock),
      .reset                 (reset),
      .item_valid            (item_valid),
      .item_ctrl             (item_ctrl),
      .item_sample           (item_sample),
      .item_delta            (item_delta),
      .item_ddelta           (item_ddelta),
      .item_dcode            (item_dcode),
      .item_ddcode           (item_ddcode),
      .out_free              (out_free),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_delta_code        (rsp_delta_code),
      .rsp_double_delta_code (rsp_double_delta_code),
      .rsp_sample_min        (rsp_sample_min),
      .rsp_sample_max        (rsp_sample_max),
      .rsp_delta_min         (rsp_delta_min),
      .rsp_delta_max         (rsp_delta_max),
      .rsp_ddelta_min        (rsp_ddelta_min),
      .rsp_ddelta_max        (rsp_ddelta_max),
      .rsp_delta_width       (rsp_delta_width),
      .rsp_ddelta_width      (rsp_ddelta_width),
      .rsp_stats_valid       (rsp_stats_valid)
   );

endmodule

// ===== src/ddz_ram.sv =====
// ----------------------------------------------------------------------------
// ddz_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ddz_ram #(
   parameter int WIDTH = 25,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/ddz_delta_stage.sv =====
// ----------------------------------------------------------------------------
// ddz_delta_stage
// Request intake, delta, reference store access and double delta stages.
// ----------------------------------------------------------------------------
module ddz_delta_stage #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_mode,
   input  logic signed [SAMPLE_BITS-1:0]     req_sample,
   input  logic [ddz_pkg::INDEX_BITS-1:0]    req_sample_index,
   input  logic                              req_last,
   input  logic                              out_free,
   output logic                              item_valid,
   output ddz_pkg::ctrl_type                 item_ctrl,
   output logic signed [SAMPLE_BITS-1:0]     item_sample,
   output logic signed [SAMPLE_BITS:0]       item_delta,
   output logic signed [SAMPLE_BITS+1:0]     item_ddelta,
   output logic [SAMPLE_BITS:0]              item_dcode,
   output logic [SAMPLE_BITS+1:0]            item_ddcode
);

   localparam int DB  = SAMPLE_BITS + 1;
   localparam int DDB = SAMPLE_BITS + 2;

   logic                          s1_free;
   logic                          s2_free;
   logic                          accept;
   ddz_pkg::ctrl_type             req_ctrl;
   logic signed [DB-1:0]          delta_calc;
   logic [DB-1:0]                 ref_delta;
   logic signed [DDB-1:0]         ddelta_calc;

   logic signed [SAMPLE_BITS-1:0] prev_sample_ff, prev_sample_in;
   logic                          s1_valid_ff, s1_valid_in;
   ddz_pkg::ctrl_type             s1_ctrl_ff;
   logic signed [SAMPLE_BITS-1:0] s1_sample_ff;
   logic signed [DB-1:0]          s1_delta_ff;
   logic                          s2_valid_ff, s2_valid_in;
   ddz_pkg::ctrl_type             s2_ctrl_ff;
   logic signed [SAMPLE_BITS-1:0] s2_sample_ff;
   logic signed [DB-1:0]          s2_delta_ff;
   logic signed [DDB-1:0]         s2_ddelta_ff;
   logic [DB-1:0]                 s2_dcode_ff;
   logic [DDB-1:0]                s2_ddcode_ff;

   // Squeeze bubbles: a stage takes a new request when it empties or moves on
   assign s2_free   = !s2_valid_ff || out_free;
   assign s1_free   = !s1_valid_ff || s2_free;
   assign accept    = req_valid && s1_free;
   assign req_stall = !s1_free;

   always_comb begin
      req_ctrl.first   = (req_sample_index == '0);
      req_ctrl.compare = (req_mode == ddz_pkg::MODE_COMPARE);
      req_ctrl.last    = req_last;
      if (req_ctrl.first) begin
         delta_calc = DB'(req_sample);
      end else begin
         delta_calc = DB'(req_sample) - DB'(prev_sample_ff);
      end
      prev_sample_in = accept ? req_sample : prev_sample_ff;
      s1_valid_in    = s1_free ? req_valid : s1_valid_ff;
      s2_valid_in    = s2_free ? s1_valid_ff : s2_valid_ff;
   end

   // Reference series writes its delta, compared series reads it back.
   // A write lands at its acceptance edge, so any later read sees it.
   ddz_ram #(
      .WIDTH (DB),
      .DEPTH (ddz_pkg::MAX_SAMPLES)
   ) u_ref_ram (
      .clock   (clock),
      .wr_en   (accept && !req_ctrl.compare),
      .wr_addr (req_sample_index),
      .wr_data (delta_calc),
      .rd_en   (accept && req_ctrl.compare),
      .rd_addr (req_sample_index),
      .rd_data (ref_delta)
   );

   always_comb begin
      if (s1_ctrl_ff.compare) begin
         ddelta_calc = DDB'(s1_delta_ff) - DDB'($signed(ref_delta));
      end else begin
         ddelta_calc = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_sample_ff <= '0;
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
      end else begin
         prev_sample_ff <= prev_sample_in;
         s1_valid_ff    <= s1_valid_in;
         s2_valid_ff    <= s2_valid_in;
      end
      if (accept) begin
         s1_ctrl_ff   <= req_ctrl;
         s1_sample_ff <= req_sample;
         s1_delta_ff  <= delta_calc;
      end
      if (s2_free && s1_valid_ff) begin
         s2_ctrl_ff   <= s1_ctrl_ff;
         s2_sample_ff <= s1_sample_ff;
         s2_delta_ff  <= s1_delta_ff;
         s2_ddelta_ff <= ddelta_calc;
         // zigzag: 0,-1,1,-2,... to 0,1,2,3,...
         s2_dcode_ff  <= {s1_delta_ff[DB-2:0], 1'b0} ^ {DB{s1_delta_ff[DB-1]}};
         s2_ddcode_ff <= {ddelta_calc[DDB-2:0], 1'b0} ^ {DDB{ddelta_calc[DDB-1]}};
      end
   end

   assign item_valid  = s2_valid_ff;
   assign item_ctrl   = s2_ctrl_ff;
   assign item_sample = s2_sample_ff;
   assign item_delta  = s2_delta_ff;
   assign item_ddelta = s2_ddelta_ff;
   assign item_dcode  = s2_dcode_ff;
   assign item_ddcode = s2_ddcode_ff;

endmodule

// ===== src/ddz_stats_stage.sv =====
// ----------------------------------------------------------------------------
// ddz_stats_stage
// Running series statistics and the response output register.
// ----------------------------------------------------------------------------
module ddz_stats_stage #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    item_valid,
   input  ddz_pkg::ctrl_type                       item_ctrl,
   input  logic signed [SAMPLE_BITS-1:0]           item_sample,
   input  logic signed [SAMPLE_BITS:0]             item_delta,
   input  logic signed [SAMPLE_BITS+1:0]           item_ddelta,
   input  logic [SAMPLE_BITS:0]                    item_dcode,
   input  logic [SAMPLE_BITS+1:0]                  item_ddcode,
   output logic                                    out_free,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [SAMPLE_BITS:0]                    rsp_delta_code,
   output logic [SAMPLE_BITS+1:0]                  rsp_double_delta_code,
   output logic signed [SAMPLE_BITS-1:0]           rsp_sample_min,
   output logic signed [SAMPLE_BITS-1:0]           rsp_sample_max,
   output logic signed [SAMPLE_BITS:0]             rsp_delta_min,
   output logic signed [SAMPLE_BITS:0]             rsp_delta_max,
   output logic signed [SAMPLE_BITS+1:0]           rsp_ddelta_min,
   output logic signed [SAMPLE_BITS+1:0]           rsp_ddelta_max,
   output logic [ddz_pkg::WIDTH_FIELD_BITS-1:0]    rsp_delta_width,
   output logic [ddz_pkg::WIDTH_FIELD_BITS-1:0]    rsp_ddelta_width,
   output logic                                    rsp_stats_valid
);

   localparam int SB       = SAMPLE_BITS;
   localparam int DB       = SAMPLE_BITS + 1;
   localparam int DDB      = SAMPLE_BITS + 2;
   localparam int LEN_BITS = $clog2(DDB + 1);
   localparam int WFB      = ddz_pkg::WIDTH_FIELD_BITS;

   // Bit length of a code, zero for a zero code
   function automatic logic [LEN_BITS-1:0] bit_len(input logic [DDB-1:0] v);
      logic [LEN_BITS-1:0] n;
      n = '0;
      for (int i = 0; i < DDB; i++) begin
         if (v[i]) begin
            n = LEN_BITS'(i + 1);
         end
      end
      return n;
   endfunction

   function automatic logic [WFB-1:0] width_field(input logic [LEN_BITS-1:0] n);
      logic [LEN_BITS-1:0] m;
      m = (n == '0) ? LEN_BITS'(1) : n;
      return WFB'(m);
   endfunction

   logic                   load;
   logic [LEN_BITS-1:0]    dlen, ddlen;

   logic signed [SB-1:0]   smin_ff, smin_in, smax_ff, smax_in;
   logic signed [DB-1:0]   dmin_ff, dmin_in, dmax_ff, dmax_in;
   logic signed [DDB-1:0]  ddmin_ff, ddmin_in, ddmax_ff, ddmax_in;
   logic [LEN_BITS-1:0]    dlen_ff, dlen_in, ddlen_ff, ddlen_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [DB-1:0]          dcode_ff;
   logic [DDB-1:0]         ddcode_ff;
   logic signed [SB-1:0]   out_smin_ff, out_smax_ff;
   logic signed [DB-1:0]   out_dmin_ff, out_dmax_ff;
   logic signed [DDB-1:0]  out_ddmin_ff, out_ddmax_ff;
   logic [WFB-1:0]         out_dwidth_ff, out_ddwidth_ff;
   logic                   stats_valid_ff;

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign load         = item_valid && out_free;
   assign rsp_valid_in = out_free ? item_valid : rsp_valid_ff;

   // Track the widest code rather than the largest code: same answer
   assign dlen  = bit_len(DDB'(item_dcode));
   assign ddlen = bit_len(item_ddcode);

   always_comb begin
      if (item_ctrl.first) begin
         smin_in  = item_sample;
         smax_in  = item_sample;
         dmin_in  = item_delta;
         dmax_in  = item_delta;
         ddmin_in = item_ddelta;
         ddmax_in = item_ddelta;
         dlen_in  = dlen;
         ddlen_in = ddlen;
      end else begin
         smin_in  = (item_sample < smin_ff) ? item_sample : smin_ff;
         smax_in  = (item_sample > smax_ff) ? item_sample : smax_ff;
         dmin_in  = (item_delta < dmin_ff) ? item_delta : dmin_ff;
         dmax_in  = (item_delta > dmax_ff) ? item_delta : dmax_ff;
         ddmin_in = (item_ddelta < ddmin_ff) ? item_ddelta : ddmin_ff;
         ddmax_in = (item_ddelta > ddmax_ff) ? item_ddelta : ddmax_ff;
         dlen_in  = (dlen > dlen_ff) ? dlen : dlen_ff;
         ddlen_in = (ddlen > ddlen_ff) ? ddlen : ddlen_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         smin_ff      <= '0;
         smax_ff      <= '0;
         dmin_ff      <= '0;
         dmax_ff      <= '0;
         ddmin_ff     <= '0;
         ddmax_ff     <= '0;
         dlen_ff      <= '0;
         ddlen_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (load) begin
            // Clear after the final request of a series
            if (item_ctrl.last) begin
               smin_ff  <= '0;
               smax_ff  <= '0;
               dmin_ff  <= '0;
               dmax_ff  <= '0;
               ddmin_ff <= '0;
               ddmax_ff <= '0;
               dlen_ff  <= '0;
               ddlen_ff <= '0;
            end else begin
               smin_ff  <= smin_in;
               smax_ff  <= smax_in;
               dmin_ff  <= dmin_in;
               dmax_ff  <= dmax_in;
               ddmin_ff <= ddmin_in;
               ddmax_ff <= ddmax_in;
               dlen_ff  <= dlen_in;
               ddlen_ff <= ddlen_in;
            end
         end
      end
      if (load) begin
         dcode_ff       <= item_dcode;
         ddcode_ff      <= item_ddcode;
         stats_valid_ff <= item_ctrl.last;
         if (item_ctrl.last) begin
            out_smin_ff    <= smin_in;
            out_smax_ff    <= smax_in;
            out_dmin_ff    <= dmin_in;
            out_dmax_ff    <= dmax_in;
            out_ddmin_ff   <= ddmin_in;
            out_ddmax_ff   <= ddmax_in;
            out_dwidth_ff  <= width_field(dlen_in);
            out_ddwidth_ff <= width_field(ddlen_in);
         end else begin
            out_smin_ff    <= '0;
            out_smax_ff    <= '0;
            out_dmin_ff    <= '0;
            out_dmax_ff    <= '0;
            out_ddmin_ff   <= '0;
            out_ddmax_ff   <= '0;
            out_dwidth_ff  <= '0;
            out_ddwidth_ff <= '0;
         end
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_delta_code        = dcode_ff;
   assign rsp_double_delta_code = ddcode_ff;
   assign rsp_sample_min        = out_smin_ff;
   assign rsp_sample_max        = out_smax_ff;
   assign rsp_delta_min         = out_dmin_ff;
   assign rsp_delta_max         = out_dmax_ff;
   assign rsp_ddelta_min        = out_ddmin_ff;
   assign rsp_ddelta_max        = out_ddmax_ff;
   assign rsp_delta_width       = out_dwidth_ff;
   assign rsp_ddelta_width      = out_ddwidth_ff;
   assign rsp_stats_valid       = stats_valid_ff;

endmodule

// ===== src/ddz_checker.sv =====
// ----------------------------------------------------------------------------
// ddz_checker
// Port-level checks on the encoder response channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ddz_checker #(
   parameter int SAMPLE_BITS = 24
) (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    rsp_valid,
   input logic                                    rsp_stall,
   input logic [SAMPLE_BITS:0]                    rsp_delta_code,
   input logic [SAMPLE_BITS+1:0]                  rsp_double_delta_code,
   input logic signed [SAMPLE_BITS-1:0]           rsp_sample_min,
   input logic signed [SAMPLE_BITS-1:0]           rsp_sample_max,
   input logic signed [SAMPLE_BITS:0]             rsp_delta_min,
   input logic signed [SAMPLE_BITS:0]             rsp_delta_max,
   input logic signed [SAMPLE_BITS+1:0]           rsp_ddelta_min,
   input logic signed [SAMPLE_BITS+1:0]           rsp_ddelta_max,
   input logic [ddz_pkg::WIDTH_FIELD_BITS-1:0]    rsp_delta_width,
   input logic [ddz_pkg::WIDTH_FIELD_BITS-1:0]    rsp_ddelta_width,
   input logic                                    rsp_stats_valid
);

   localparam int PAYLOAD_BITS = 8 * SAMPLE_BITS + 2 * ddz_pkg::WIDTH_FIELD_BITS + 10;

   logic [PAYLOAD_BITS-1:0] rsp_bits;
   logic                    stats_zero;
   logic                    stats_ordered;

   // Whole response payload, for the hold check
   assign rsp_bits = {rsp_delta_code, rsp_double_delta_code, rsp_sample_min, rsp_sample_max,
                      rsp_delta_min, rsp_delta_max, rsp_ddelta_min, rsp_ddelta_max,
                      rsp_delta_width, rsp_ddelta_width, rsp_stats_valid};

   assign stats_zero = rsp_sample_min == '0 && rsp_sample_max == '0 &&
                       rsp_delta_min == '0 && rsp_delta_max == '0 &&
                       rsp_ddelta_min == '0 && rsp_ddelta_max == '0 &&
                       rsp_delta_width == '0 && rsp_ddelta_width == '0;

   assign stats_ordered = rsp_sample_min <= rsp_sample_max &&
                          rsp_delta_min <= rsp_delta_max &&
                          rsp_ddelta_min <= rsp_ddelta_max;

   // No response straight out of reset
   `ASSERT_CLK_NORST(a_quiet_after_reset, clock, reset |=> !rsp_valid)

   // Hold a stalled response
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_bits))

   // Statistics read zero on every response but the last of a series
   `ASSERT_CLK(a_stats_zero, clock, reset, rsp_valid && !rsp_stats_valid |-> stats_zero)

   // Reported extremes are ordered
   `ASSERT_CLK(a_stats_order, clock, reset, rsp_valid && rsp_stats_valid |-> stats_ordered)

endmodule

bind delta_double_delta_zigzag_encoder ddz_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_ddz_checker (.*);
